// ===== rtl/three_band_biquad_equalizer_core_assert.svh =====
// ============================================================================
// three_band_biquad_equalizer_core_assert.svh
// Assertion macros shared by the equalizer checker.
// ============================================================================
`ifndef THREE_BAND_BIQUAD_EQUALIZER_CORE_ASSERT_SVH
`define THREE_BAND_BIQUAD_EQUALIZER_CORE_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define TBEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define TBEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tbeq_pkg.sv =====
// ============================================================================
// tbeq_pkg
// Types, constants and helpers for the three-band biquad equalizer.
// ============================================================================
`timescale 1ns / 1ps

package tbeq_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Fixed datapath widths
    localparam int STATE_BITS = 40;   // delay terms and section outputs
    localparam int COEF_BITS  = 21;   // one coefficient field
    localparam int NUM_SECT   = 3;
    localparam int NUM_REGS   = 5;
    localparam int REG_BITS   = COEF_BITS * NUM_SECT;  // 63
    localparam int PROD_BITS  = COEF_BITS + STATE_BITS; // 61
    localparam int ACC_BITS   = 64;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;    // 8-byte register spacing

    typedef logic signed [STATE_BITS-1:0] t_state;
    typedef logic signed [COEF_BITS-1:0]  t_coef;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [ACC_BITS-1:0]   t_acc;
    typedef logic [REG_BITS-1:0]          t_coef_reg;

    // Register indexes
    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_fsm;

    // Steps within one section
    typedef enum logic [2:0] {
        PH_B0 = 3'd0,   // b0*x; finish previous section's n2
        PH_B1 = 3'd1,   // b1*x; y sum; store previous z2
        PH_Y  = 3'd2,   // latch y; start n1 sum
        PH_A1 = 3'd3,   // a1*y
        PH_B2 = 3'd4,   // b2*x; subtract a1*y
        PH_A2 = 3'd5    // a2*y; store z1; start n2 sum
    } t_phase;

    // Accumulator operations
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_SUB,        // acc - product
        ACC_ADD_Z,      // product + delay term + rounding half
        ACC_ADD_HALF    // product + rounding half
    } t_acc_op;

    // Per-cycle datapath controls
    typedef struct packed {
        logic     mul_en;
        t_reg_idx coef_sel;
        logic     mul_use_y;
        t_acc_op  acc_op;
        logic     z_sel_z2;
        logic     wr_y;
        logic     wr_z1;
        logic     wr_z2;
        logic     load_x;
        logic     done;
    } t_ctrl;

    // Limit a rounded value to the state range
    function automatic t_state sat_state(input t_acc v);
        t_acc hi;
        t_acc lo;
        hi = (t_acc'(1) <<< (STATE_BITS - 1)) - t_acc'(1);
        lo = -hi - t_acc'(1);
        if (v > hi) begin
            sat_state = STATE_BITS'(hi);
        end else if (v < lo) begin
            sat_state = STATE_BITS'(lo);
        end else begin
            sat_state = STATE_BITS'(v);
        end
    endfunction

endpackage

// ===== rtl/three_band_biquad_equalizer_core.sv =====
// ============================================================================
// three_band_biquad_equalizer_core
// Three cascaded TDF-II biquads (low shelf, mid peak, high shelf) on one
// shared multiply-accumulate unit.
// ============================================================================
// Usage:
//   Input stream (s_axis): one signed sample per word in tdata.
//   Output stream (m_axis): one equalized, saturated sample per input word.
//   APB port: five 63-bit coefficient registers at byte offsets 0x00..0x20
//   (b0, b1, b2, a1, a2), each holding low/mid/high Q4.16 fields from bit 0.
//   Write coefficients only while no sample is in flight.
// Sequencing:
//   Each sample runs 6 steps per section times 3 sections plus 2 closing
//   steps, all paced by the one 21x40 multiplier and accumulator. tready
//   is high only in idle, so the block takes no new sample until the last
//   one has reached its final closing step.
// Reset:
//   Delay terms clear, every section passes its input through (b0 = 1.0),
//   output valid drops.
// Stall:
//   A finished word waits in the output register. A new sample can be
//   accepted meanwhile; its last step holds until the old word is taken.
// ============================================================================
`timescale 1ns / 1ps

module three_band_biquad_equalizer_core #(
    parameter int SAMPLE_BITS    = tbeq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = tbeq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Input stream
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  i_s_axis_tdata,  // [SB-1:0] audio_in
    // Output stream
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  o_m_axis_tdata,  // [SB-1:0] audio_out
    // Configuration
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [tbeq_pkg::APB_ADDR_W-1:0]           paddr,
    input  logic [tbeq_pkg::APB_DATA_W-1:0]           pwdata,
    output logic [tbeq_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam tbeq_pkg::t_coef     COEF_ONE  =
        tbeq_pkg::COEF_BITS'(64'sd1 <<< COEF_FRAC_BITS);
    localparam tbeq_pkg::t_coef_reg B0_RESET  = {tbeq_pkg::NUM_SECT{COEF_ONE}};
    localparam tbeq_pkg::t_acc      RND_HALF  =
        tbeq_pkg::t_acc'(1) <<< (COEF_FRAC_BITS - 1);
    localparam tbeq_pkg::t_state    SMP_MAX   =
        tbeq_pkg::STATE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam tbeq_pkg::t_state    SMP_MIN   = -SMP_MAX - tbeq_pkg::t_state'(1);

    // Round (half already added) and limit to state range
    function automatic tbeq_pkg::t_state round_state(input tbeq_pkg::t_acc a);
        tbeq_pkg::t_acc sh;
        sh = a >>> COEF_FRAC_BITS;
        round_state = tbeq_pkg::sat_state(sh);
    endfunction

    // Registers
    tbeq_pkg::t_fsm       r_state, n_state;
    tbeq_pkg::t_phase     r_ph;
    logic [1:0]           r_sec;            // 0..2 sections, 3 = closing steps
    tbeq_pkg::t_coef_reg  r_coef [tbeq_pkg::NUM_REGS];
    tbeq_pkg::t_state     r_z1 [tbeq_pkg::NUM_SECT];
    tbeq_pkg::t_state     r_z2 [tbeq_pkg::NUM_SECT];
    tbeq_pkg::t_state     r_x;
    tbeq_pkg::t_state     r_y;
    tbeq_pkg::t_prod      r_prod;
    tbeq_pkg::t_acc       r_acc, n_acc;
    logic                 r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out;

    tbeq_pkg::t_ctrl      w_ctrl;
    logic                 w_en;
    logic                 w_in_acc;
    logic [1:0]           w_sec;
    logic [1:0]           w_sec_prev;
    tbeq_pkg::t_coef      w_coef;
    tbeq_pkg::t_state     w_mop;
    tbeq_pkg::t_state     w_z;
    tbeq_pkg::t_acc       w_prod_ext;
    tbeq_pkg::t_acc       w_z_ext;
    tbeq_pkg::t_state     w_y_sat;
    logic [2:0]           w_ridx;

    // Handshakes
    assign o_s_axis_tready = (r_state == tbeq_pkg::ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_en            = !(w_ctrl.done && r_out_valid && !i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_W'(r_out);

    // Section index clamped for coefficient and delay selection
    assign w_sec      = (r_sec == 2'd3) ? 2'd2 : r_sec;
    assign w_sec_prev = r_sec - 2'd1;

    // FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbeq_pkg::ST_IDLE: begin
                if (w_in_acc) n_state = tbeq_pkg::ST_RUN;
            end
            tbeq_pkg::ST_RUN: begin
                if (w_ctrl.done && w_en) n_state = tbeq_pkg::ST_IDLE;
            end
            default: n_state = tbeq_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs: per-step datapath controls
    always_comb begin
        w_ctrl           = '0;
        w_ctrl.coef_sel  = tbeq_pkg::REG_B0;
        w_ctrl.acc_op    = tbeq_pkg::ACC_HOLD;
        if (r_state == tbeq_pkg::ST_RUN) begin
            case (r_ph)
                tbeq_pkg::PH_B0: begin
                    w_ctrl.mul_en = (r_sec != 2'd3);
                    if (r_sec != 2'd0) w_ctrl.acc_op = tbeq_pkg::ACC_SUB;
                end
                tbeq_pkg::PH_B1: begin
                    w_ctrl.wr_z2 = (r_sec != 2'd0);
                    if (r_sec == 2'd3) begin
                        w_ctrl.done = 1'b1;
                    end else begin
                        w_ctrl.mul_en   = 1'b1;
                        w_ctrl.coef_sel = tbeq_pkg::REG_B1;
                        w_ctrl.acc_op   = tbeq_pkg::ACC_ADD_Z;
                    end
                end
                tbeq_pkg::PH_Y: begin
                    w_ctrl.wr_y     = 1'b1;
                    w_ctrl.acc_op   = tbeq_pkg::ACC_ADD_Z;
                    w_ctrl.z_sel_z2 = 1'b1;
                end
                tbeq_pkg::PH_A1: begin
                    w_ctrl.mul_en    = 1'b1;
                    w_ctrl.coef_sel  = tbeq_pkg::REG_A1;
                    w_ctrl.mul_use_y = 1'b1;
                end
                tbeq_pkg::PH_B2: begin
                    w_ctrl.mul_en   = 1'b1;
                    w_ctrl.coef_sel = tbeq_pkg::REG_B2;
                    w_ctrl.acc_op   = tbeq_pkg::ACC_SUB;
                end
                tbeq_pkg::PH_A2: begin
                    w_ctrl.mul_en    = 1'b1;
                    w_ctrl.coef_sel  = tbeq_pkg::REG_A2;
                    w_ctrl.mul_use_y = 1'b1;
                    w_ctrl.acc_op    = tbeq_pkg::ACC_ADD_HALF;
                    w_ctrl.wr_z1     = 1'b1;
                    w_ctrl.load_x    = 1'b1;
                end
                default: w_ctrl.acc_op = tbeq_pkg::ACC_HOLD;
            endcase
        end
    end

    // Sequencer counters and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbeq_pkg::ST_IDLE;
            r_ph    <= tbeq_pkg::PH_B0;
            r_sec   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_ph  <= tbeq_pkg::PH_B0;
                r_sec <= 2'd0;
            end else if (r_state == tbeq_pkg::ST_RUN && w_en) begin
                if (r_ph == tbeq_pkg::PH_A2) begin
                    r_ph  <= tbeq_pkg::PH_B0;
                    r_sec <= r_sec + 2'd1;
                end else begin
                    r_ph  <= tbeq_pkg::t_phase'(r_ph + 3'd1);
                end
            end
        end
    end

    // Multiplier operands and registered product
    assign w_coef = r_coef[w_ctrl.coef_sel][tbeq_pkg::COEF_BITS * w_sec +: tbeq_pkg::COEF_BITS];
    assign w_mop  = w_ctrl.mul_use_y ? r_y : r_x;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.mul_en && w_en) begin
            r_prod <= w_coef * w_mop;
        end
    end

    // Accumulator
    assign w_z        = w_ctrl.z_sel_z2 ? r_z2[w_sec] : r_z1[w_sec];
    assign w_prod_ext = tbeq_pkg::t_acc'(r_prod);
    assign w_z_ext    = tbeq_pkg::t_acc'(w_z) <<< COEF_FRAC_BITS;

    always_comb begin
        case (w_ctrl.acc_op)
            tbeq_pkg::ACC_SUB:      n_acc = r_acc - w_prod_ext;
            tbeq_pkg::ACC_ADD_Z:    n_acc = w_prod_ext + w_z_ext + RND_HALF;
            tbeq_pkg::ACC_ADD_HALF: n_acc = w_prod_ext + RND_HALF;
            default:                n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_acc <= n_acc;
    end

    // Sample, section output and section input
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= tbeq_pkg::t_state'($signed(i_s_axis_tdata[SAMPLE_BITS-1:0]));
        end else if (w_ctrl.load_x && w_en) begin
            r_x <= r_y;
        end
        if (w_ctrl.wr_y && w_en) r_y <= round_state(r_acc);
    end

    // Delay terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tbeq_pkg::NUM_SECT; i++) begin
                r_z1[i] <= '0;
                r_z2[i] <= '0;
            end
        end else if (w_en) begin
            if (w_ctrl.wr_z1) r_z1[w_sec]      <= round_state(r_acc);
            if (w_ctrl.wr_z2) r_z2[w_sec_prev] <= round_state(r_acc);
        end
    end

    // Output saturation and register
    always_comb begin
        if (r_y > SMP_MAX) begin
            w_y_sat = SMP_MAX;
        end else if (r_y < SMP_MIN) begin
            w_y_sat = SMP_MIN;
        end else begin
            w_y_sat = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.done && w_en) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.done && w_en) r_out <= w_y_sat[SAMPLE_BITS-1:0];
    end

    // Configuration registers
    assign pready = 1'b1;
    assign w_ridx = paddr[tbeq_pkg::APB_ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[tbeq_pkg::REG_B0] <= B0_RESET;
            r_coef[tbeq_pkg::REG_B1] <= '0;
            r_coef[tbeq_pkg::REG_B2] <= '0;
            r_coef[tbeq_pkg::REG_A1] <= '0;
            r_coef[tbeq_pkg::REG_A2] <= '0;
        end else if (psel && penable && pwrite && pready
                     && (w_ridx < 3'(tbeq_pkg::NUM_REGS))) begin
            r_coef[w_ridx] <= pwdata[tbeq_pkg::REG_BITS-1:0];
        end
    end

    always_comb begin
        if (w_ridx < 3'(tbeq_pkg::NUM_REGS)) begin
            prdata = tbeq_pkg::APB_DATA_W'(r_coef[w_ridx]);
        end else begin
            prdata = '0;
        end
    end

endmodule

// ===== rtl/tbeq_checker.sv =====
// ============================================================================
// tbeq_checker
// Port-level checks for the equalizer core, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "three_band_biquad_equalizer_core_assert.svh"

module tbeq_checker #(
    parameter int SAMPLE_BITS = tbeq_pkg::SAMPLE_BITS_DEF
) (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      i_s_axis_tvalid,
    input logic                                      o_s_axis_tready,
    input logic                                      o_m_axis_tvalid,
    input logic                                      i_m_axis_tready,
    input logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  o_m_axis_tdata
);

    logic w_in_word;
    assign w_in_word = i_s_axis_tvalid && o_s_axis_tready;

    // Stalled output word stays offered
    `TBEQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "output word dropped while stalled")

    // Stalled output word keeps its value
    `TBEQ_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "output word changed while stalled")

    // One sample at a time: busy right after accepting a word
    `TBEQ_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, w_in_word, !o_s_axis_tready, "input ready right after accept")

    // No result can appear the cycle after a sample is taken
    `TBEQ_ASSERT_NXT(a_no_early_out, i_clk, i_rst_n, w_in_word, !$rose(o_m_axis_tvalid), "output appeared too early")

endmodule

bind three_band_biquad_equalizer_core tbeq_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_tbeq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
